>>> rtl/etps_pkg.sv
// shared types and constants for the event timer period setup block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package etps_pkg;

	localparam int unsigned CLOCK_HZ = 16000000;
	localparam int unsigned QUOT_MAX = 16320;
	localparam int unsigned QUOT_W = 14;
	localparam int unsigned TCLK_W = 27;
	localparam int unsigned DVD_W = QUOT_W + TCLK_W;
	localparam int unsigned DSR_W = 32;
	localparam int unsigned CNT_W = 6;
	localparam int unsigned NUM_PRE = 5;
	localparam int unsigned PRE_W = 3;
	localparam logic [DSR_W-1:0] US_PER_S = DSR_W'(1000000);
	localparam int unsigned OUT_BITS = 45;
	localparam int unsigned OUT_TDATA_W = 48;

	// timer clock for each prescaler
	function automatic logic [TCLK_W-1:0] tclk_of(input logic [PRE_W-1:0] idx);
		logic [TCLK_W-1:0] r;
		begin
			unique case (idx)
				3'd0: r = TCLK_W'(CLOCK_HZ / 1);
				3'd1: r = TCLK_W'(CLOCK_HZ / 8);
				3'd2: r = TCLK_W'(CLOCK_HZ / 64);
				3'd3: r = TCLK_W'(CLOCK_HZ / 256);
				3'd4: r = TCLK_W'(CLOCK_HZ / 1024);
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [DSR_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK_GO,
		ST_TICK_WAIT,
		ST_SRCH_GO,
		ST_SRCH_WAIT,
		ST_MUL,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

>>> rtl/etps_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on etps_pkg
`timescale 1ns / 1ps
`default_nettype none
module etps_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire etps_pkg::div_req_t req,
	output etps_pkg::div_rsp_t      rsp
);
	import etps_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             qbit;

	// one restoring step
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, dsr_q};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

>>> rtl/event_timer_period_setup.sv
// event timer period setup: divisor search, prescaler pick and event tick counter
// depends on etps_pkg and etps_div
//
// channel  dir  tdata                                      tuser
// s_axis   in   micros[31:0]                               func
// m_axis   out  ok, prescale_sel, compare_value,           -
//               event_ceiling, event_fire (48 bits)
//
// every division runs in a shared bit-serial divider: a load, one shift per dividend bit, then done
// tick beat: a divider pass for (count + 1) mod ceiling; the next beat is accepted only back in idle
// program beat: a divider pass per divisor candidate (16320 down to 2, up to 16319 tries)
// plus a multiply and a divider pass per prescaler tried (up to five)
// reset sets ceiling 1, count 0, timer stopped; a stalled result holds the block in done
`timescale 1ns / 1ps
`default_nettype none
module event_timer_period_setup (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // micros[31:0]
	input  wire logic        s_tuser,  // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [etps_pkg::OUT_TDATA_W-1:0] m_tdata
	// m_tdata: ok[0], prescale_sel[3:1], compare_value[11:4], event_ceiling[43:12],
	// event_fire[44], zero pad
);
	import etps_pkg::*;

	state_t state_q, state_d;

	logic [31:0]       period_q;
	logic [QUOT_W-1:0] cand_q;
	logic [QUOT_W-1:0] quot_q;
	logic [PRE_W-1:0]  pre_q;
	logic [DVD_W-1:0]  prod_q;
	logic [31:0]       ceiling_q;
	logic [31:0]       count_q;
	logic [PRE_W-1:0]  sel_q;
	logic [7:0]        cmp_q;
	logic              ok_q;
	logic              fire_q;
	logic              mvalid_q;
	logic [OUT_BITS-1:0] mdata_q;

	div_req_t dreq;
	div_rsp_t drsp;
	logic     cnt_fits;
	logic     out_free;

	etps_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	assign cnt_fits = (drsp.quot[DVD_W-1:8] == '0) && (drsp.quot[7:0] != 8'd0);
	assign out_free = !mvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// divider operands by state
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = US_PER_S;
		unique case (state_q)
			ST_TICK_GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = DVD_W'({1'b0, count_q} + 33'd1);
				dreq.divisor  = ceiling_q;
			end
			ST_SRCH_GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = DVD_W'(period_q);
				dreq.divisor  = DSR_W'(cand_q);
			end
			ST_SCALE_GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = prod_q;
				dreq.divisor  = US_PER_S;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser)
						state_d = ST_TICK_GO;
					else if (s_tdata <= 32'(QUOT_MAX))
						state_d = ST_MUL;
					else
						state_d = ST_SRCH_GO;
				end
			end
			ST_TICK_GO:   state_d = ST_TICK_WAIT;
			ST_TICK_WAIT: if (drsp.done) state_d = ST_DONE;
			ST_SRCH_GO:   state_d = ST_SRCH_WAIT;
			ST_SRCH_WAIT: begin
				if (drsp.done) begin
					if (drsp.rem == '0 || cand_q == QUOT_W'(2))
						state_d = ST_MUL;
					else
						state_d = ST_SRCH_GO;
				end
			end
			ST_MUL:       state_d = ST_SCALE_GO;
			ST_SCALE_GO:  state_d = ST_SCALE_WAIT;
			ST_SCALE_WAIT: begin
				if (drsp.done) begin
					if (cnt_fits || pre_q == PRE_W'(NUM_PRE - 1))
						state_d = ST_DONE;
					else
						state_d = ST_MUL;
				end
			end
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// timer state and per-beat work registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= 32'd1;
			count_q   <= '0;
			sel_q     <= '0;
			cmp_q     <= '0;
			ok_q      <= 1'b0;
			fire_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ok_q   <= 1'b0;
						fire_q <= s_tuser && (count_q == '0);
						if (!s_tuser && s_tdata <= 32'(QUOT_MAX))
							ceiling_q <= 32'd1;
					end
				end
				ST_TICK_WAIT: if (drsp.done) count_q <= drsp.rem;
				ST_SRCH_WAIT: begin
					if (drsp.done) begin
						if (drsp.rem == '0)
							ceiling_q <= drsp.quot[31:0];
						else if (cand_q == QUOT_W'(2))
							ceiling_q <= period_q;
					end
				end
				ST_SCALE_WAIT: begin
					if (drsp.done && cnt_fits) begin
						ok_q  <= 1'b1;
						sel_q <= pre_q + 1'b1;
						cmp_q <= drsp.quot[7:0];
					end
				end
				default: ;
			endcase
		end
	end

	// search and scale work registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				period_q <= s_tdata;
				cand_q   <= QUOT_W'(QUOT_MAX);
				quot_q   <= s_tdata[QUOT_W-1:0];
				pre_q    <= '0;
			end
			ST_SRCH_WAIT: begin
				if (drsp.done) begin
					if (drsp.rem == '0)
						quot_q <= cand_q;
					else if (cand_q == QUOT_W'(2))
						quot_q <= QUOT_W'(1);
					else
						cand_q <= cand_q - 1'b1;
				end
			end
			ST_MUL:  prod_q <= DVD_W'(quot_q) * DVD_W'(tclk_of(pre_q));
			ST_SCALE_WAIT: if (drsp.done && !cnt_fits) pre_q <= pre_q + 1'b1;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mvalid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free)
			mvalid_q <= 1'b1;
		else if (m_tready)
			mvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free)
			mdata_q <= {fire_q, ceiling_q, cmp_q, sel_q, ok_q};
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, mdata_q};

	// checks
	a_ceiling_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ceiling_q != '0) else $error("event ceiling became zero");
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q <= PRE_W'(NUM_PRE)) else $error("clock select out of range");
	a_ok_fire_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(mdata_q[0] && mdata_q[OUT_BITS-1]))
		else $error("ok and event fire in one beat");
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy) else $error("divider started while busy");

endmodule
`default_nettype wire
